@@ hw/rtl/pbc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types and codes for the pinned buffer cache slot directory.
// ----------------------------------------------------------------------------
package pbc_pkg;

    // command codes
    localparam logic [1:0] CMD_GET   = 2'd0;
    localparam logic [1:0] CMD_PUT   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_OK           = 3'd0;
    localparam logic [2:0] STAT_ALL_PINNED   = 3'd1;
    localparam logic [2:0] STAT_PIN_OVERFLOW = 3'd2;
    localparam logic [2:0] STAT_NOT_PINNED   = 3'd3;
    localparam logic [2:0] STAT_BAD_SLOT     = 3'd4;

    localparam int          ACTIVE_W     = 5;
    localparam logic [4:0]  ACTIVE_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [30:0] block_number;
        logic [3:0]  slot_index;
    } in_t;

    typedef struct packed {
        logic [3:0]  slot;
        logic        hit;
        logic        fill_request;
        logic        writeback_request;
        logic [30:0] device_block;
        logic [2:0]  status;
    } out_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;  // capture request and lane compare results
        logic exec;  // apply update and write result register
    } ctrl_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/pbc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbc_ctrl
// Sequencer: accept a request, execute it once the result register is free.
// ----------------------------------------------------------------------------
module pbc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pbc_pkg::ctrl_cmd_t     cmd
);

    pbc_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pbc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        s_ready    = 1'b0;
        case (state_reg)
            pbc_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = pbc_pkg::ST_EXEC;
                end
            end
            pbc_pkg::ST_EXEC: begin
                // hold until the result register drains
                if (!out_valid_reg || m_ready) begin
                    cmd.exec   = 1'b1;
                    state_next = pbc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pbc_pkg::ST_IDLE;
            end
        endcase

        if (cmd.exec) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule
`default_nettype wire

@@ hw/rtl/pbc_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pbc_datapath
// Slot tags, valid marks, pin counts, clock hand and the result register.
// ----------------------------------------------------------------------------
module pbc_datapath #(
    parameter int NUM_SLOTS = 16,
    parameter int PIN_BITS  = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [pbc_pkg::ACTIVE_W-1:0] cfg_wr_data,
    input  wire pbc_pkg::in_t                 s_payload,
    output pbc_pkg::out_t                     m_payload,
    input  wire pbc_pkg::ctrl_cmd_t           cmd
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int KW     = (CNT_W > pbc_pkg::ACTIVE_W) ? CNT_W : pbc_pkg::ACTIVE_W;
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    logic [30:0]          slot_block_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [PIN_BITS-1:0]  pins_reg [NUM_SLOTS];
    logic [SLOT_W-1:0]    hand_reg;
    logic [pbc_pkg::ACTIVE_W-1:0] active_reg;
    pbc_pkg::in_t         req_reg;
    logic [NUM_SLOTS-1:0] match_reg;
    logic [NUM_SLOTS-1:0] free_reg;
    pbc_pkg::out_t        out_reg;

    function automatic logic [SLOT_W-1:0] first_set(input logic [NUM_SLOTS-1:0] v);
        logic [NUM_SLOTS-1:0] low;
        logic [SLOT_W-1:0]    idx;
        low = v & (~v + 1'b1);
        idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (low[i]) begin
                idx = idx | SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    // live count: zero acts as one, clamp to the slot count
    logic [KW-1:0] act_ext, live_n;
    always_comb begin
        act_ext = KW'(active_reg);
        if (act_ext == '0) begin
            live_n = KW'(1);
        end else if (act_ext > KW'(NUM_SLOTS)) begin
            live_n = KW'(NUM_SLOTS);
        end else begin
            live_n = act_ext;
        end
    end

    // lane compare, captured with the request
    logic [NUM_SLOTS-1:0] live_lane, match_next, free_next;
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            live_lane[i]  = KW'(i) < live_n;
            match_next[i] = live_lane[i] && valid_reg[i] &&
                            (slot_block_reg[i] == s_payload.block_number);
            free_next[i]  = live_lane[i] && (pins_reg[i] == '0);
        end
    end

    // execute decisions
    logic [KW-1:0]        hand_inc, start;
    logic [NUM_SLOTS-1:0] free_hi;
    logic [SLOT_W-1:0]    hit_idx, victim_idx, put_idx;
    logic [KW-1:0]        idx_ext;
    pbc_pkg::out_t        out_next;
    logic                 pin_inc, pin_dec, do_fill, do_clear;

    always_comb begin
        hand_inc = KW'(hand_reg) + KW'(1);
        start    = (hand_inc >= live_n) ? '0 : hand_inc;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            free_hi[i] = free_reg[i] && (KW'(i) >= start);
        end
        hit_idx    = first_set(match_reg);
        victim_idx = (|free_hi) ? first_set(free_hi) : first_set(free_reg);
        idx_ext    = KW'(req_reg.slot_index);
        put_idx    = idx_ext[SLOT_W-1:0];

        out_next = '0;
        pin_inc  = 1'b0;
        pin_dec  = 1'b0;
        do_fill  = 1'b0;
        do_clear = 1'b0;
        case (req_reg.cmd)
            pbc_pkg::CMD_GET: begin
                if (|match_reg) begin
                    out_next.slot = 4'(hit_idx);
                    out_next.hit  = 1'b1;
                    if (pins_reg[hit_idx] == PIN_MAX) begin
                        out_next.status = pbc_pkg::STAT_PIN_OVERFLOW;
                    end else begin
                        pin_inc = 1'b1;
                    end
                end else if (|free_reg) begin
                    do_fill                = 1'b1;
                    out_next.slot          = 4'(victim_idx);
                    out_next.fill_request  = 1'b1;
                    out_next.device_block  = req_reg.block_number;
                end else begin
                    out_next.status = pbc_pkg::STAT_ALL_PINNED;
                end
            end
            pbc_pkg::CMD_PUT: begin
                out_next.slot = req_reg.slot_index;
                if (idx_ext >= live_n) begin
                    out_next.status = pbc_pkg::STAT_BAD_SLOT;
                end else if (pins_reg[put_idx] == '0) begin
                    out_next.status = pbc_pkg::STAT_NOT_PINNED;
                end else begin
                    pin_dec                    = 1'b1;
                    out_next.writeback_request = 1'b1;
                    out_next.device_block      = slot_block_reg[put_idx];
                end
            end
            pbc_pkg::CMD_CLEAR: begin
                do_clear = 1'b1;
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            hand_reg   <= '0;
            active_reg <= pbc_pkg::ACTIVE_RESET;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                pins_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                active_reg <= cfg_wr_data;
            end
            if (cmd.exec) begin
                if (do_clear) begin
                    valid_reg <= '0;
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        pins_reg[i] <= '0;
                    end
                end
                if (pin_inc) begin
                    pins_reg[hit_idx] <= pins_reg[hit_idx] + PIN_BITS'(1);
                end
                if (pin_dec) begin
                    pins_reg[put_idx] <= pins_reg[put_idx] - PIN_BITS'(1);
                end
                if (do_fill) begin
                    valid_reg[victim_idx] <= 1'b1;
                    pins_reg[victim_idx]  <= PIN_BITS'(1);
                    hand_reg              <= victim_idx;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= s_payload;
            match_reg <= match_next;
            free_reg  <= free_next;
        end
        if (cmd.exec) begin
            out_reg <= out_next;
            if (do_fill) begin
                slot_block_reg[victim_idx] <= req_reg.block_number;
            end
        end
    end

    assign m_payload = out_reg;

endmodule
`default_nettype wire

@@ hw/rtl/pinned_buffer_cache_clock_replace.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pinned_buffer_cache_clock_replace
// Buffer slot directory with pin counts and a rotating clock replacement hand.
// Sequence: a request is accepted and loaded in the idle state; in the
//   execute state the result register loads and then offers the result.
// A new request is taken only once the previous one has executed; execute
//   holds while the result register is full.
// Reset: valid marks, pin counts and the clock hand clear at once, active
//   slots returns to 16; block tags are not reset and need no clearing pass.
// ----------------------------------------------------------------------------
module pinned_buffer_cache_clock_replace #(
    parameter int NUM_SLOTS = 16,
    parameter int PIN_BITS  = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration: active slot count
    input  wire logic                         cfg_wr_en,
    input  wire logic [pbc_pkg::ACTIVE_W-1:0] cfg_wr_data,
    // request channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire pbc_pkg::in_t                 s_payload,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output pbc_pkg::out_t                     m_payload
);

    // Commands from the sequencer to the datapath. A load captures the
    // request together with the per-slot tag match and unpinned vectors;
    // an execute picks the hit slot or the next unpinned slot past the
    // clock hand, updates the directory and writes the result register.
    pbc_pkg::ctrl_cmd_t ctrl_cmd;

    pbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (ctrl_cmd)
    );

    pbc_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .PIN_BITS  (PIN_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_payload   (s_payload),
        .m_payload   (m_payload),
        .cmd         (ctrl_cmd)
    );

endmodule
`default_nettype wire

@@ tb/tb_pinned_buffer_cache_clock_replace.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_pinned_buffer_cache_clock_replace
// Self-checking bench for the pinned buffer cache slot directory. A short
// table of directed transactions covers reset state, field extremes, every
// command and every error status but pin overflow. A pin saturation run
// follows, then random phases over several active-slot settings. Results
// are checked field by field in order against a directory model or typed row.
// ----------------------------------------------------------------------------
module tb_pinned_buffer_cache_clock_replace;

    // the command encoding leaves one code unused
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int          SLOTS        = 16;
    localparam logic [7:0]  PIN_SAT      = 8'hFF;
    localparam logic [30:0] BLOCK_TOP    = 31'h7FFF_FFFF;
    localparam int          POOL_SIZE    = 12;
    localparam int          PHASE_ITEMS  = 60;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          LIMIT_CYCLES = 200000;

    logic          aclk;
    logic          aresetn;
    logic          cfg_wr_en;
    logic [4:0]    cfg_wr_data;
    logic          s_valid;
    logic          s_ready;
    pbc_pkg::in_t  s_payload;
    logic          m_valid;
    logic          m_ready;
    pbc_pkg::out_t m_payload;

    pinned_buffer_cache_clock_replace i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

    // ------------------------------------------------------------------------
    // Directory model: tags, valid marks, pin counts, clock hand, active count
    // ------------------------------------------------------------------------
    logic [30:0] tag_block [SLOTS];
    logic        tag_valid [SLOTS];
    logic [7:0]  pin_cnt   [SLOTS];
    logic [3:0]  hand;
    logic [4:0]  active_reg;

    // results still owed by the block, oldest first
    pbc_pkg::out_t due_results [$];

    // run bookkeeping
    int unsigned n_fail;
    int unsigned n_items;
    int unsigned n_checked;
    int unsigned n_settings;
    int unsigned n_hit;
    int unsigned n_fill;
    int unsigned n_wb;
    int unsigned n_err;
    int unsigned n_overflow;
    int unsigned cycles;

    // idling control shared with the receiver
    bit          quiet;
    int unsigned hold_ask;

    logic [30:0] block_pool [POOL_SIZE];

    // directed table
    typedef struct {
        bit            is_cfg;
        logic [4:0]    cfg_value;
        pbc_pkg::in_t  req;
        bit            fixed;
        pbc_pkg::out_t want;
    } plan_row_t;

    plan_row_t plan [$];

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // End the run if the block stops making progress.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycles, due_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model step: clamp the active count, then apply one command
    // ------------------------------------------------------------------------
    function automatic int unsigned live_slots();
        int unsigned n;
        n = 32'(active_reg);
        if (n == 0) n = 1;
        if (n > SLOTS) n = SLOTS;
        return n;
    endfunction

    task automatic directory_step(input pbc_pkg::in_t req, output pbc_pkg::out_t res);
        int unsigned n;
        int unsigned pos;
        int unsigned idx;
        bit          found;
        res   = '0;
        n     = live_slots();
        found = 1'b0;
        case (req.cmd)
            pbc_pkg::CMD_GET: begin
                // search active valid slots, lowest index wins
                for (int i = 0; i < n; i++) begin
                    if (!found && tag_valid[i] && tag_block[i] == req.block_number) begin
                        found   = 1'b1;
                        res.slot = i[3:0];
                        res.hit  = 1'b1;
                        if (pin_cnt[i] == PIN_SAT) begin
                            res.status = pbc_pkg::STAT_PIN_OVERFLOW;
                        end else begin
                            pin_cnt[i] = pin_cnt[i] + 8'd1;
                        end
                    end
                end
                // miss: advance the hand to the next unpinned slot and retag it
                pos = 32'(hand);
                for (int i = 0; i < n; i++) begin
                    if (!found) begin
                        pos = pos + 1;
                        if (pos >= n) pos = 0;
                        if (pin_cnt[pos] == 8'd0) begin
                            found            = 1'b1;
                            hand             = pos[3:0];
                            tag_block[pos]   = req.block_number;
                            tag_valid[pos]   = 1'b1;
                            pin_cnt[pos]     = 8'd1;
                            res.slot         = pos[3:0];
                            res.fill_request = 1'b1;
                            res.device_block = req.block_number;
                        end
                    end
                end
                if (!found) res.status = pbc_pkg::STAT_ALL_PINNED;
            end
            pbc_pkg::CMD_PUT: begin
                idx      = 32'(req.slot_index);
                res.slot = req.slot_index;
                if (idx >= n) begin
                    res.status = pbc_pkg::STAT_BAD_SLOT;
                end else if (pin_cnt[idx] == 8'd0) begin
                    res.status = pbc_pkg::STAT_NOT_PINNED;
                end else begin
                    pin_cnt[idx]          = pin_cnt[idx] - 8'd1;
                    res.writeback_request = 1'b1;
                    res.device_block      = tag_block[idx];
                end
            end
            pbc_pkg::CMD_CLEAR: begin
                // tags and the clock hand survive a clear
                for (int i = 0; i < SLOTS; i++) begin
                    tag_valid[i] = 1'b0;
                    pin_cnt[i]   = 8'd0;
                end
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic pbc_pkg::in_t mk(input logic [1:0] cmd, input logic [30:0] blk,
                                        input logic [3:0] idx);
        pbc_pkg::in_t r;
        r.cmd          = cmd;
        r.block_number = blk;
        r.slot_index   = idx;
        return r;
    endfunction

    task automatic plan_cfg(input logic [4:0] v);
        plan_row_t row;
        row           = '{default: '0};
        row.is_cfg    = 1'b1;
        row.cfg_value = v;
        plan.push_back(row);
    endtask

    task automatic plan_req(input logic [1:0] cmd, input logic [30:0] blk,
                            input logic [3:0] idx);
        plan_row_t row;
        row     = '{default: '0};
        row.req = mk(cmd, blk, idx);
        plan.push_back(row);
    endtask

    // rows whose result has only a slot and a status worth typing in
    task automatic plan_fixed(input logic [1:0] cmd, input logic [30:0] blk,
                              input logic [3:0] idx, input logic [3:0] slot,
                              input logic [2:0] status);
        plan_row_t row;
        row             = '{default: '0};
        row.req         = mk(cmd, blk, idx);
        row.fixed       = 1'b1;
        row.want        = '0;
        row.want.slot   = slot;
        row.want.status = status;
        plan.push_back(row);
    endtask

    // Offer one transaction, idling first at random; record the owed result
    // at the edge that accepts it.
    task automatic offer(input pbc_pkg::in_t req, input bit fixed,
                         input pbc_pkg::out_t want);
        pbc_pkg::out_t pred;
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        directory_step(req, pred);
        due_results.push_back(fixed ? want : pred);
        n_items++;
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write the active slot count; the caller drains first.
    task automatic set_active(input logic [4:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        active_reg = v;
        n_settings++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed traffic: gets from a small block pool so hits and
    // pin buildup happen, puts aimed at pinned slots, plus some noise.
    function automatic pbc_pkg::in_t pick_request();
        pbc_pkg::in_t r;
        logic [31:0]  w;
        logic [31:0]  x;
        int unsigned  roll;
        int unsigned  n;
        logic [3:0]   cand [$];
        w      = $urandom;
        x      = $urandom;
        r      = mk(pbc_pkg::CMD_GET, block_pool[$urandom_range(POOL_SIZE - 1)], x[3:0]);
        roll   = $urandom_range(99);
        n      = live_slots();
        if (roll < 45) begin
            r.cmd = pbc_pkg::CMD_GET;
        end else if (roll < 82) begin
            for (int i = 0; i < n; i++) begin
                if (pin_cnt[i] != 8'd0) cand.push_back(i[3:0]);
            end
            if (cand.size() != 0) begin
                r.cmd        = pbc_pkg::CMD_PUT;
                r.slot_index = cand[$urandom_range(cand.size() - 1)];
            end
            r.block_number = w[30:0];
        end else if (roll < 90) begin
            r.cmd          = pbc_pkg::CMD_PUT;
            r.block_number = w[30:0];
        end else if (roll < 95) begin
            r.cmd          = pbc_pkg::CMD_CLEAR;
            r.block_number = w[30:0];
        end else if (roll < 97) begin
            r.cmd          = CMD_UNUSED;
            r.block_number = w[30:0];
        end else begin
            r.block_number = w[30:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, a quiet stretch, and one long hold-off
    // ------------------------------------------------------------------------
    initial begin : receiver
        int unsigned hold_seen;
        int unsigned hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 16);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d, result %0d: %s got 0x%0h want 0x%0h",
                 cycles, n_checked, what, got, want);
        n_fail++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    pbc_pkg::out_t want_res;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("result with no transaction pending",
                                32'(m_payload.slot), 32'd0);
            end else begin
                want_res = due_results.pop_front();
                check_field("slot",              32'(m_payload.slot),
                            32'(want_res.slot));
                check_field("hit",               32'(m_payload.hit),
                            32'(want_res.hit));
                check_field("fill_request",      32'(m_payload.fill_request),
                            32'(want_res.fill_request));
                check_field("writeback_request", 32'(m_payload.writeback_request),
                            32'(want_res.writeback_request));
                check_field("device_block",      32'(m_payload.device_block),
                            32'(want_res.device_block));
                check_field("status",            32'(m_payload.status),
                            32'(want_res.status));
                n_checked++;
                if (want_res.hit)                                  n_hit++;
                if (want_res.fill_request)                         n_fill++;
                if (want_res.writeback_request)                    n_wb++;
                if (want_res.status != pbc_pkg::STAT_OK)           n_err++;
                if (want_res.status == pbc_pkg::STAT_PIN_OVERFLOW) n_overflow++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        logic [30:0] hot_block;
        logic [3:0]  hot_slot;
        logic [4:0]  phase_active;
        logic [31:0] w;

        // hold every input at a known value from time zero
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_payload   = '0;
        quiet       = 1'b0;
        hold_ask    = 0;
        n_fail      = 0;
        n_items     = 0;
        n_checked   = 0;
        n_settings  = 0;
        n_hit       = 0;
        n_fill      = 0;
        n_wb        = 0;
        n_err       = 0;
        n_overflow  = 0;

        // model starts from the reset state
        active_reg = pbc_pkg::ACTIVE_RESET;
        hand       = '0;
        for (int i = 0; i < SLOTS; i++) begin
            tag_block[i] = '0;
            tag_valid[i] = 1'b0;
            pin_cnt[i]   = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            w             = $urandom;
            block_pool[i] = w[30:0];
        end

        // directed table
        plan_fixed(pbc_pkg::CMD_PUT, 31'd0, 4'd0, 4'd0,
                   pbc_pkg::STAT_NOT_PINNED);                     // fresh from reset
        plan_fixed(pbc_pkg::CMD_PUT, BLOCK_TOP, 4'd15, 4'd15, pbc_pkg::STAT_NOT_PINNED);
        plan_req  (pbc_pkg::CMD_GET, 31'd0,     4'd15);           // miss, fill
        plan_req  (pbc_pkg::CMD_GET, BLOCK_TOP, 4'd0);            // miss, top block
        plan_req  (pbc_pkg::CMD_GET, 31'd0,     4'd0);            // hit
        plan_req  (pbc_pkg::CMD_PUT, 31'd0,     4'd1);            // write-back
        plan_req  (pbc_pkg::CMD_PUT, BLOCK_TOP, 4'd2);
        plan_fixed(pbc_pkg::CMD_PUT, 31'd0, 4'd2, 4'd2, pbc_pkg::STAT_NOT_PINNED);
        plan_fixed(CMD_UNUSED, BLOCK_TOP, 4'd15, 4'd0,
                   pbc_pkg::STAT_OK);                             // unknown command
        plan_fixed(pbc_pkg::CMD_CLEAR, BLOCK_TOP, 4'd15, 4'd0, pbc_pkg::STAT_OK);
        plan_req  (pbc_pkg::CMD_GET, BLOCK_TOP, 4'd0);            // miss after clear
        plan_cfg  (5'd1);
        plan_req  (pbc_pkg::CMD_GET, 31'd5,     4'd0);            // hand past count wraps
        plan_fixed(pbc_pkg::CMD_GET, 31'd6, 4'd0, 4'd0, pbc_pkg::STAT_ALL_PINNED);
        plan_fixed(pbc_pkg::CMD_PUT, 31'd0, 4'd1, 4'd1, pbc_pkg::STAT_BAD_SLOT);
        plan_fixed(pbc_pkg::CMD_PUT, 31'd0, 4'd15, 4'd15, pbc_pkg::STAT_BAD_SLOT);
        plan_req  (pbc_pkg::CMD_PUT, 31'd0,     4'd0);
        plan_cfg  (5'd0);                                         // zero acts as one
        plan_req  (pbc_pkg::CMD_GET, 31'd7,     4'd0);
        plan_fixed(pbc_pkg::CMD_PUT, 31'd0, 4'd1, 4'd1, pbc_pkg::STAT_BAD_SLOT);
        plan_cfg  (5'd31);                                        // clamps to all slots
        plan_fixed(pbc_pkg::CMD_PUT, 31'd0, 4'd15, 4'd15, pbc_pkg::STAT_NOT_PINNED);
        plan_req  (pbc_pkg::CMD_GET, 31'd9,     4'd7);
        plan_fixed(pbc_pkg::CMD_CLEAR, 31'd0, 4'd0, 4'd0, pbc_pkg::STAT_OK);
        plan_cfg  (5'd16);

        // reset once, release at a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // walk the directed table; write the register only when idle
        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                drain();
                set_active(plan[k].cfg_value);
            end else begin
                offer(plan[k].req, plan[k].fixed, plan[k].want);
            end
        end

        // Pin one slot up to saturation and past it, then release a pin and
        // pin it again.
        drain();
        set_active(5'd16);
        offer(mk(pbc_pkg::CMD_CLEAR, 31'd0, 4'd0), 1'b0, '0);
        w         = $urandom;
        hot_block = w[30:0];
        repeat (257) offer(mk(pbc_pkg::CMD_GET, hot_block, 4'($urandom)), 1'b0, '0);
        hot_slot = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (tag_valid[i] && tag_block[i] == hot_block) hot_slot = i[3:0];
        end
        offer(mk(pbc_pkg::CMD_PUT, 31'($urandom), hot_slot), 1'b0, '0);
        offer(mk(pbc_pkg::CMD_GET, hot_block, 4'($urandom)), 1'b0, '0);
        offer(mk(pbc_pkg::CMD_GET, hot_block, 4'($urandom)), 1'b0, '0);

        // random phases over several active counts, extremes included
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       phase_active = 5'd1;
                1:       phase_active = 5'd16;
                2:       phase_active = 5'd2;
                4:       phase_active = $urandom_range(1) ? 5'd0 : 5'($urandom_range(31, 17));
                default: phase_active = 5'($urandom_range(16, 1));
            endcase
            drain();
            set_active(phase_active);
            quiet = (p == 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // stall the receiver long enough to back the block up
                if (p == 3 && k == 10) hold_ask++;
                offer(pick_request(), 1'b0, '0);
            end
        end
        quiet = 1'b0;

        // let the tail of results arrive, then idle before reporting
        drain();
        repeat (4) @(posedge aclk);

        $display("ran %0d transactions over %0d active-slot settings; %0d results checked",
                 n_items, n_settings, n_checked);
        $display("hits %0d, fills %0d, write-backs %0d, error statuses %0d (pin overflow %0d)",
                 n_hit, n_fill, n_wb, n_err, n_overflow);
        if (n_fail == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
